// ===== sv/uefr_pkg.sv =====
package uefr_pkg;

    // Header geometry
    localparam int HDR_LEN   = 38;
    localparam int HDR_IDX_W = 6;
    localparam int POS_W     = 6;

    // Byte offsets within the frame
    localparam logic [POS_W-1:0] POS_MAC_LAST   = 6'd5;
    localparam logic [POS_W-1:0] POS_ETYPE_HI   = 6'd12;
    localparam logic [POS_W-1:0] POS_ETYPE_LO   = 6'd13;
    localparam logic [POS_W-1:0] POS_IP_FIRST   = 6'd14;
    localparam logic [POS_W-1:0] POS_PROTO      = 6'd23;
    localparam logic [POS_W-1:0] POS_IPCK_HI    = 6'd24;
    localparam logic [POS_W-1:0] POS_IPCK_LO    = 6'd25;
    localparam logic [POS_W-1:0] POS_DIP_FIRST  = 6'd30;
    localparam logic [POS_W-1:0] POS_DIP_LAST   = 6'd33;
    localparam logic [POS_W-1:0] POS_DPORT_HI   = 6'd36;
    localparam logic [POS_W-1:0] POS_HDR_LAST   = 6'd37;
    localparam logic [POS_W-1:0] POS_FWD_FIRST  = 6'd38;
    localparam logic [POS_W-1:0] POS_UDPCK_HI   = 6'd40;
    localparam logic [POS_W-1:0] POS_UDPCK_LO   = 6'd41;
    localparam logic [POS_W-1:0] POS_MAX        = 6'd63;

    // Protocol constants
    localparam logic [7:0]  ETYPE_IPV4_HI = 8'h08;
    localparam logic [7:0]  ETYPE_IPV4_LO = 8'h00;
    localparam logic [7:0]  IP_PROTO_UDP  = 8'd17;
    localparam logic [15:0] ECHO_PORT_RST = 16'd7;

    // Configuration register indexes
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 48;
    localparam logic [CFG_IDX_W-1:0] CFG_STATION_MAC = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STATION_IP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ECHO_PORT   = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic                 store;
        logic [POS_W-1:0]     pos;
        logic                 emit_rd;
        logic                 emit_load;
        logic                 emit_end;
        logic [HDR_IDX_W-1:0] emit_idx;
        logic                 fwd_load;
        logic                 fwd_end;
    } uefr_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;
        logic frame_ok;
    } uefr_stat_t;

    // Header entry that supplies reply byte idx (MACs, IPs and ports swapped)
    function automatic logic [HDR_IDX_W-1:0] reply_src(input logic [HDR_IDX_W-1:0] idx);
        logic [HDR_IDX_W-1:0] src;
        src = idx;
        case (idx) inside
            [6'd0:6'd5]:   src = idx + 6'd6;
            [6'd6:6'd11]:  src = idx - 6'd6;
            [6'd26:6'd29]: src = idx + 6'd4;
            [6'd30:6'd33]: src = idx - 6'd4;
            [6'd34:6'd35]: src = idx + 6'd2;
            [6'd36:6'd37]: src = idx - 6'd2;
            default:       src = idx;
        endcase
        return src;
    endfunction

endpackage

// ===== sv/uefr_stream_if.sv =====
interface uefr_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_end;

    modport source (output valid, output frame_byte, output frame_end, input ready);
    modport sink   (input valid, input frame_byte, input frame_end, output ready);
endinterface

interface uefr_reply_if;
    logic       valid;
    logic       ready;
    logic [7:0] reply_byte;
    logic       reply_end;

    modport source (output valid, output reply_byte, output reply_end, input ready);
    modport sink   (input valid, input reply_byte, input reply_end, output ready);
endinterface

// ===== sv/uefr_datapath.sv =====
module uefr_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  uefr_pkg::uefr_cmd_t           cmd,
    output uefr_pkg::uefr_stat_t          stat,
    input  logic [7:0]                    in_byte,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [7:0]                    out_byte,
    output logic                          out_end,
    input  logic                          cfg_we,
    input  logic [uefr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [uefr_pkg::CFG_DATA_W-1:0] cfg_data
);
    import uefr_pkg::*;

    logic [47:0] station_mac_reg;
    logic [31:0] station_ip_reg;
    logic [15:0] echo_port_reg;

    logic [7:0]  hdr_mem [HDR_LEN];
    logic [7:0]  rd_data_reg;

    logic [47:0] dst_mac_reg;
    logic [31:0] dst_ip_reg;
    logic [7:0]  port_hi_reg;
    logic        type_ok_reg;
    logic        proto_ok_reg;
    logic        ck_nz_reg;
    logic [7:0]  word_hi_reg;
    logic [15:0] ck_acc_reg;
    logic [15:0] ck_acc_next;
    logic [16:0] ck_sum;
    logic        ck_word;

    logic        out_vld_reg;
    logic [7:0]  out_byte_reg;
    logic        out_end_reg;
    logic [7:0]  emit_byte;
    logic [7:0]  fwd_byte;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            station_mac_reg <= '0;
            station_ip_reg  <= '0;
            echo_port_reg   <= ECHO_PORT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_STATION_MAC: station_mac_reg <= cfg_data[47:0];
                CFG_STATION_IP:  station_ip_reg  <= cfg_data[31:0];
                CFG_ECHO_PORT:   echo_port_reg   <= cfg_data[15:0];
                default:         ;
            endcase
        end
    end

    // Header store: write on arrival, registered read for the reply burst
    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            hdr_mem[cmd.pos] <= in_byte;
        end
        if (cmd.emit_rd)
        begin
            rd_data_reg <= hdr_mem[reply_src(cmd.emit_idx)];
        end
    end

    // Add one header word with end-around carry
    always_comb
    begin
        ck_word = 1'b0;
        if (cmd.pos inside {[6'd15:6'd33]})
        begin
            ck_word = cmd.pos[0] && (cmd.pos != POS_IPCK_LO);
        end
        ck_sum      = {1'b0, (cmd.pos == 6'd15) ? 16'd0 : ck_acc_reg}
                      + {1'b0, word_hi_reg, in_byte};
        ck_acc_next = ck_sum[15:0] + {15'd0, ck_sum[16]};
    end

    // Capture the fields that decide acceptance, and the checksum
    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            if (cmd.pos <= POS_MAC_LAST)
            begin
                dst_mac_reg <= {dst_mac_reg[39:0], in_byte};
            end
            if (cmd.pos inside {[POS_DIP_FIRST:POS_DIP_LAST]})
            begin
                dst_ip_reg <= {dst_ip_reg[23:0], in_byte};
            end
            if (cmd.pos == POS_DPORT_HI)
            begin
                port_hi_reg <= in_byte;
            end
            if (cmd.pos == POS_ETYPE_HI)
            begin
                type_ok_reg <= (in_byte == ETYPE_IPV4_HI);
            end
            if (cmd.pos == POS_ETYPE_LO)
            begin
                type_ok_reg <= type_ok_reg && (in_byte == ETYPE_IPV4_LO);
            end
            if (cmd.pos == POS_PROTO)
            begin
                proto_ok_reg <= (in_byte == IP_PROTO_UDP);
            end
            if (cmd.pos == POS_IPCK_HI)
            begin
                ck_nz_reg <= (in_byte != 8'd0);
            end
            if (cmd.pos == POS_IPCK_LO)
            begin
                ck_nz_reg <= ck_nz_reg || (in_byte != 8'd0);
            end
            if (!cmd.pos[0])
            begin
                word_hi_reg <= in_byte;
            end
            if (ck_word)
            begin
                ck_acc_reg <= ck_acc_next;
            end
        end
    end

    // Decide acceptance on the last header byte
    assign stat.frame_ok = type_ok_reg && proto_ok_reg
                           && (dst_mac_reg == station_mac_reg)
                           && (dst_ip_reg == station_ip_reg)
                           && (port_hi_reg == echo_port_reg[15:8])
                           && (in_byte == echo_port_reg[7:0]);

    // Substitute the recomputed IP checksum when the received one is nonzero, clear the UDP checksum
    always_comb
    begin
        emit_byte = rd_data_reg;
        if (ck_nz_reg && (cmd.emit_idx == POS_IPCK_HI))
        begin
            emit_byte = ~ck_acc_reg[15:8];
        end
        else if (ck_nz_reg && (cmd.emit_idx == POS_IPCK_LO))
        begin
            emit_byte = ~ck_acc_reg[7:0];
        end
        fwd_byte = in_byte;
        if ((cmd.pos == POS_UDPCK_HI) || (cmd.pos == POS_UDPCK_LO))
        begin
            fwd_byte = 8'd0;
        end
    end

    // Output register
    assign stat.out_free = !out_vld_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (cmd.emit_load || cmd.fwd_load)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_load)
        begin
            out_byte_reg <= emit_byte;
            out_end_reg  <= cmd.emit_end;
        end
        else if (cmd.fwd_load)
        begin
            out_byte_reg <= fwd_byte;
            out_end_reg  <= cmd.fwd_end;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_byte  = out_byte_reg;
    assign out_end   = out_end_reg;

    // Commands are mutually exclusive
    a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.store, cmd.emit_rd, cmd.emit_load, cmd.fwd_load}))
        else $error("uefr_datapath: overlapping commands");

    // A load never overwrites a beat that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_load || cmd.fwd_load) |-> (!out_vld_reg || out_ready))
        else $error("uefr_datapath: output beat overwritten");

endmodule

// ===== sv/uefr_ctrl.sv =====
module uefr_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_end,
    output logic                 in_ready,
    input  uefr_pkg::uefr_stat_t stat,
    output uefr_pkg::uefr_cmd_t  cmd
);
    import uefr_pkg::*;

    typedef enum logic [4:0] {
        ST_COLLECT = 5'b00001,
        ST_DISCARD = 5'b00010,
        ST_EMIT_RD = 5'b00100,
        ST_EMIT_WR = 5'b01000,
        ST_FORWARD = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [HDR_IDX_W-1:0] idx_reg, idx_next;
    logic                 end_pend_reg, end_pend_next;
    logic                 accept;

    always_comb
    begin
        state_next    = state_reg;
        pos_next      = pos_reg;
        idx_next      = idx_reg;
        end_pend_next = end_pend_reg;
        in_ready      = 1'b0;

        cmd           = '0;
        cmd.pos       = pos_reg;
        cmd.emit_idx  = idx_reg;
        cmd.fwd_end   = in_end;

        case (state_reg)
            ST_COLLECT:
            begin
                in_ready = 1'b1;
            end
            ST_DISCARD:
            begin
                in_ready = 1'b1;
            end
            ST_FORWARD:
            begin
                in_ready = stat.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
        accept = in_valid && in_ready;

        case (state_reg)
            // Store header bytes, validate on the last one
            ST_COLLECT:
            begin
                if (accept)
                begin
                    cmd.store = 1'b1;
                    if (pos_reg == POS_HDR_LAST)
                    begin
                        if (stat.frame_ok)
                        begin
                            state_next    = ST_EMIT_RD;
                            idx_next      = '0;
                            end_pend_next = in_end;
                        end
                        else if (in_end)
                        begin
                            pos_next = '0;
                        end
                        else
                        begin
                            state_next = ST_DISCARD;
                        end
                    end
                    else if (in_end)
                    begin
                        pos_next = '0;
                    end
                    else
                    begin
                        pos_next = pos_reg + 6'd1;
                    end
                end
            end
            // Drop the rest of a rejected frame
            ST_DISCARD:
            begin
                if (accept && in_end)
                begin
                    state_next = ST_COLLECT;
                    pos_next   = '0;
                end
            end
            // Read one reply header byte
            ST_EMIT_RD:
            begin
                cmd.emit_rd = 1'b1;
                state_next  = ST_EMIT_WR;
            end
            // Hand it to the output register once that is free
            ST_EMIT_WR:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_load = 1'b1;
                    cmd.emit_end  = end_pend_reg && (idx_reg == POS_HDR_LAST);
                    if (idx_reg == POS_HDR_LAST)
                    begin
                        if (end_pend_reg)
                        begin
                            state_next = ST_COLLECT;
                            pos_next   = '0;
                        end
                        else
                        begin
                            state_next = ST_FORWARD;
                            pos_next   = POS_FWD_FIRST;
                        end
                    end
                    else
                    begin
                        idx_next   = idx_reg + 6'd1;
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            // Pass payload bytes through
            ST_FORWARD:
            begin
                if (accept)
                begin
                    cmd.fwd_load = 1'b1;
                    if (in_end)
                    begin
                        state_next = ST_COLLECT;
                        pos_next   = '0;
                    end
                    else if (pos_reg != POS_MAX)
                    begin
                        pos_next = pos_reg + 6'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_COLLECT;
                pos_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_COLLECT;
            pos_reg      <= '0;
            idx_reg      <= '0;
            end_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            pos_reg      <= pos_next;
            idx_reg      <= idx_next;
            end_pend_reg <= end_pend_next;
        end
    end

    // Header collection never runs past the last header byte
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COLLECT) |-> (pos_reg <= POS_HDR_LAST))
        else $error("uefr_ctrl: header position out of range");

    // Reply end mark only on the final header byte of a frame that ended there
    a_emit_end: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_end |-> (cmd.emit_load && end_pend_reg && (idx_reg == POS_HDR_LAST)))
        else $error("uefr_ctrl: misplaced reply end mark");

    // An accepted header always leads into the reply burst from its first byte
    a_burst_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COLLECT && accept && pos_reg == POS_HDR_LAST && stat.frame_ok)
        |=> (state_reg == ST_EMIT_RD && idx_reg == '0))
        else $error("uefr_ctrl: reply burst did not start");

    // A load is issued only into a free output register
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_load || cmd.fwd_load) |-> stat.out_free)
        else $error("uefr_ctrl: load into a busy output register");

endmodule

// ===== sv/udp_echo_frame_responder.sv =====
// UDP echo responder.
// Channels: frame (sink) takes one received Ethernet byte per beat with a
// last-byte mark; reply (source) gives the echo reply one byte per beat.
// Configuration: cfg_we/cfg_index/cfg_data write station_mac (0),
// station_ip (1) and echo_port (2); other indexes are ignored.
// The first 38 bytes are taken one per cycle and checked on byte 37. An
// accepted header is replayed with MACs, IPs and ports swapped and the IPv4
// checksum recomputed if the received one is nonzero; each byte is a header
// store read, then an output register load once that is free; frame.ready
// is low for the burst. Later bytes pass one per cycle while the output
// register is free, with the UDP checksum bytes cleared. Rejected and short
// frames give no beats. Reset clears the controller, the output valid and
// the config registers (echo_port to 7). When the receiver stalls the reply
// beat holds in the output register and frame.ready drops in forwarding.
module udp_echo_frame_responder (
    input  logic                            clk,
    input  logic                            rst_n,
    uefr_frame_if.sink                      frame,
    uefr_reply_if.source                    reply,
    input  logic                            cfg_we,
    input  logic [uefr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [uefr_pkg::CFG_DATA_W-1:0] cfg_data
);
    import uefr_pkg::*;

    uefr_cmd_t  cmd;
    uefr_stat_t stat;

    uefr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (frame.valid),
        .in_end   (frame.frame_end),
        .in_ready (frame.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    uefr_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_byte   (frame.frame_byte),
        .out_valid (reply.valid),
        .out_ready (reply.ready),
        .out_byte  (reply.reply_byte),
        .out_end   (reply.reply_end),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule
